[design/rmmv_pkg.sv]
// Shared types and constants for the running min/max/mean/variance block.
package rmmv_pkg;

  // Fixed widths of the result fields
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned AVG_W    = 48;
  localparam int unsigned M2_W     = 64;

  // Multiplier digit width and the widened product used for the M2 shift
  localparam int unsigned DIG_BITS  = 8;
  localparam int unsigned PROD_EXT_W = 128;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // latch the incoming sample
    logic calc;      // update count/min/max, set up the divide
    logic div_step;  // one restoring divide iteration
    logic mul_load;  // form the new mean and d2, seed the multiplier
    logic mul_step;  // one digit of the d1*d2 product
    logic update;    // commit mean and M2
    logic publish;   // load the result register
  } rmmv_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic first;     // no sample counted yet
  } rmmv_sts_t;

endpackage

[design/rmmv_ctrl.sv]
// Sequencing state machine for the running statistics datapath.
module rmmv_ctrl #(
  parameter int unsigned DIV_STEPS = 48,
  parameter int unsigned MUL_STEPS = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  rmmv_pkg::rmmv_sts_t sts,
  output rmmv_pkg::rmmv_cmd_t cmd
);
  import rmmv_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_DIV,
    S_MEAN,
    S_MUL,
    S_UPD,
    S_PUB
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               in_xfer;
  logic               pub_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign in_xfer   = in_valid && in_ready;
  assign pub_ok    = (state_r == S_PUB) && (!out_valid_r || out_ready);

  // Decode commands from the current state
  always_comb begin
    cmd          = '0;
    cmd.capture  = in_xfer;
    cmd.calc     = (state_r == S_CALC);
    cmd.div_step = (state_r == S_DIV);
    cmd.mul_load = (state_r == S_MEAN);
    cmd.mul_step = (state_r == S_MUL);
    cmd.update   = (state_r == S_UPD);
    cmd.publish  = pub_ok;
  end

  // Next state, step counter and result valid
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        if (sts.first) begin
          state_nxt = S_PUB;
        end else begin
          state_nxt = S_DIV;
          cnt_nxt   = CNT_W'(DIV_STEPS - 1);
        end
      end
      S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = S_MEAN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_MEAN: begin
        state_nxt = S_MUL;
        cnt_nxt   = CNT_W'(MUL_STEPS - 1);
      end
      S_MUL: begin
        if (cnt_r == '0) begin
          state_nxt = S_UPD;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_UPD: begin
        state_nxt = S_PUB;
      end
      S_PUB: begin
        if (pub_ok) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[design/rmmv_dp.sv]
// Datapath: statistics registers, serial divider, digit-serial multiplier.
module rmmv_dp #(
  parameter int unsigned SAMPLE_BITS    = 32,
  parameter int unsigned MEAN_FRAC_BITS = 16,
  parameter int unsigned MUL_STEPS      = 6
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [rmmv_pkg::SAMPLE_W-1:0]       in_sample,
  input  rmmv_pkg::rmmv_cmd_t                 cmd,
  output rmmv_pkg::rmmv_sts_t                 sts,
  output logic [rmmv_pkg::COUNT_W-1:0]        out_count,
  output logic [rmmv_pkg::SAMPLE_W-1:0]       out_minimum,
  output logic [rmmv_pkg::SAMPLE_W-1:0]       out_maximum,
  output logic [rmmv_pkg::AVG_W-1:0]          out_average,
  output logic [rmmv_pkg::M2_W-1:0]           out_sum_sq_dev
);
  import rmmv_pkg::*;

  localparam int unsigned MW    = SAMPLE_BITS + MEAN_FRAC_BITS;
  localparam int unsigned LW    = DIG_BITS * MUL_STEPS;
  localparam int unsigned TW    = MW + DIG_BITS;
  localparam int unsigned FW    = MW + LW;
  localparam int unsigned TWO_F = 2 * MEAN_FRAC_BITS;

  // Architectural state
  logic [COUNT_W-1:0]     count_r;
  logic [SAMPLE_BITS-1:0] min_r, max_r;
  logic [MW-1:0]          mean_r;
  logic [M2_W-1:0]        m2_r;

  // Working registers
  logic [SAMPLE_BITS-1:0] x_r;
  logic                   up_r;
  logic [MW-1:0]          d1_r, quot_r, newmean_r;
  logic [COUNT_W-1:0]     rem_r;
  logic [MW-1:0]          hi_r;
  logic [LW-1:0]          lo_r;

  // Result register
  logic [COUNT_W-1:0]     res_count_r;
  logic [SAMPLE_W-1:0]    res_min_r, res_max_r;
  logic [AVG_W-1:0]       res_avg_r;
  logic [M2_W-1:0]        res_m2_r;

  logic [MW-1:0]          xf;
  logic                   up;
  logic [MW-1:0]          d1;
  logic [COUNT_W:0]       rem_sh, rem_diff;
  logic                   div_ge;
  logic [MW-1:0]          newmean, d2;
  logic [TW-1:0]          mac;
  logic [FW-1:0]          prod;
  logic [PROD_EXT_W-1:0]  prod_sh;
  logic [M2_W:0]          m2_sum;
  logic                   m2_sat;

  assign sts.first = (count_r == '0);

  // Sample in mean format and the first difference
  assign xf = MW'(x_r) << MEAN_FRAC_BITS;
  assign up = (xf >= mean_r);
  assign d1 = up ? (xf - mean_r) : (mean_r - xf);

  // Restoring divide step: shift in the next dividend bit
  assign rem_sh   = {rem_r, quot_r[MW-1]};
  assign rem_diff = rem_sh - {1'b0, count_r};
  assign div_ge   = (rem_sh >= {1'b0, count_r});

  // New mean and second difference
  assign newmean = up_r ? (mean_r + quot_r) : (mean_r - quot_r);
  assign d2      = up_r ? (xf - newmean) : (newmean - xf);

  // One digit of d1 * d2 with the running high part
  assign mac = TW'(hi_r) + TW'(d1_r) * TW'(lo_r[DIG_BITS-1:0]);

  // Drop the fraction bits of the product and add to M2 with saturation
  assign prod    = {hi_r, lo_r};
  assign prod_sh = PROD_EXT_W'(prod) >> TWO_F;
  assign m2_sum  = {1'b0, m2_r} + {1'b0, prod_sh[M2_W-1:0]};
  assign m2_sat  = (|prod_sh[PROD_EXT_W-1:M2_W]) || m2_sum[M2_W];

  // Statistics state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      min_r   <= '0;
      max_r   <= '0;
      mean_r  <= '0;
      m2_r    <= '0;
    end else begin
      if (cmd.calc) begin
        if (count_r == '0) begin
          count_r <= COUNT_W'(1);
          min_r   <= x_r;
          max_r   <= x_r;
          mean_r  <= xf;
        end else begin
          if (count_r != '1) begin
            count_r <= count_r + 1'b1;
          end
          if (x_r < min_r) begin
            min_r <= x_r;
          end
          if (x_r > max_r) begin
            max_r <= x_r;
          end
        end
      end
      if (cmd.update) begin
        mean_r <= newmean_r;
        m2_r   <= m2_sat ? '1 : m2_sum[M2_W-1:0];
      end
    end
  end

  // Working registers: capture, divide, multiply
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r <= in_sample[SAMPLE_BITS-1:0];
    end
    if (cmd.calc) begin
      up_r   <= up;
      d1_r   <= d1;
      quot_r <= d1;
      rem_r  <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= div_ge ? rem_diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
      quot_r <= {quot_r[MW-2:0], div_ge};
    end
    if (cmd.mul_load) begin
      newmean_r <= newmean;
      hi_r      <= '0;
      lo_r      <= LW'(d2);
    end
    if (cmd.mul_step) begin
      hi_r <= mac[TW-1:DIG_BITS];
      lo_r <= (lo_r >> DIG_BITS) | (LW'(mac[DIG_BITS-1:0]) << (LW - DIG_BITS));
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      res_count_r <= count_r;
      res_min_r   <= SAMPLE_W'(min_r);
      res_max_r   <= SAMPLE_W'(max_r);
      res_avg_r   <= AVG_W'(mean_r);
      res_m2_r    <= m2_r;
    end
  end

  assign out_count      = res_count_r;
  assign out_minimum    = res_min_r;
  assign out_maximum    = res_max_r;
  assign out_average    = res_avg_r;
  assign out_sum_sq_dev = res_m2_r;

endmodule

[design/running_min_max_mean_variance.sv]
// The first sample after reset goes from the calc state straight to publish. Later
// samples also pass the one-bit-per-cycle restoring divide by the count and the
// 8-bit-per-cycle multiplier before publish. One item in flight; the next sample
// is taken while a finished result waits. Synchronous active-low reset clears all
// stats.
module running_min_max_mean_variance #(
  parameter int unsigned SAMPLE_BITS    = 32,
  parameter int unsigned MEAN_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rmmv_pkg::SAMPLE_W-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rmmv_pkg::COUNT_W-1:0]  out_count,
  output logic [rmmv_pkg::SAMPLE_W-1:0] out_minimum,
  output logic [rmmv_pkg::SAMPLE_W-1:0] out_maximum,
  output logic [rmmv_pkg::AVG_W-1:0]    out_average,
  output logic [rmmv_pkg::M2_W-1:0]     out_sum_sq_dev
);
  import rmmv_pkg::*;

  localparam int unsigned MEAN_W    = SAMPLE_BITS + MEAN_FRAC_BITS;
  localparam int unsigned MUL_STEPS = (MEAN_W + DIG_BITS - 1) / DIG_BITS;

  rmmv_cmd_t cmd;
  rmmv_sts_t sts;

  // Sequencer
  rmmv_ctrl #(
    .DIV_STEPS (MEAN_W),
    .MUL_STEPS (MUL_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and state
  rmmv_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .MEAN_FRAC_BITS (MEAN_FRAC_BITS),
    .MUL_STEPS      (MUL_STEPS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_sample      (in_sample),
    .cmd            (cmd),
    .sts            (sts),
    .out_count      (out_count),
    .out_minimum    (out_minimum),
    .out_maximum    (out_maximum),
    .out_average    (out_average),
    .out_sum_sq_dev (out_sum_sq_dev)
  );

endmodule

[tb/running_min_max_mean_variance_tb.sv]
// Self-checking testbench for running_min_max_mean_variance, with a built-in Welford predictor.
`timescale 1ns / 1ps

module running_min_max_mean_variance_tb;
  import rmmv_pkg::*;

  localparam int unsigned SAMPLE_BITS = 32;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned DIR_ROWS    = 25;
  localparam int unsigned OPEN_ROWS   = 15;   // rows before the random part
  localparam int unsigned RAND_ITEMS  = 930;
  localparam int unsigned IDLE_PCT    = 7;
  localparam int unsigned CALM_LO     = 300;  // no idling on either side in this window
  localparam int unsigned CALM_HI     = 500;
  localparam int unsigned HOLD_AT     = 620;  // results seen before the long hold-off
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_WAIT  = 80;
  localparam int unsigned STALL_LIMIT = 3000;

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [SAMPLE_W-1:0] minimum;
    logic [SAMPLE_W-1:0] maximum;
    logic [AVG_W-1:0]    average;
    logic [M2_W-1:0]     sum_sq_dev;
  } stats_t;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    bit                  typed;
    stats_t              want;
  } row_t;

  localparam stats_t NO_STATS = '0;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [SAMPLE_W-1:0] in_sample;
  logic                out_valid;
  logic                out_ready;
  logic [COUNT_W-1:0]  out_count;
  logic [SAMPLE_W-1:0] out_minimum;
  logic [SAMPLE_W-1:0] out_maximum;
  logic [AVG_W-1:0]    out_average;
  logic [M2_W-1:0]     out_sum_sq_dev;

  // Predictor state
  logic [COUNT_W-1:0]  run_count;
  logic [SAMPLE_W-1:0] run_min;
  logic [SAMPLE_W-1:0] run_max;
  logic [63:0]         run_mean;
  logic [M2_W-1:0]     run_m2;

  stats_t              pending_stats[$];
  row_t                dir_rows[DIR_ROWS];
  logic [SAMPLE_W-1:0] last_sample;
  int unsigned         sent_count;
  int unsigned         seen_count;
  int unsigned         err_count;
  int unsigned         quiet_cycles;

  running_min_max_mean_variance #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .MEAN_FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_count     (out_count),
    .out_minimum   (out_minimum),
    .out_maximum   (out_maximum),
    .out_average   (out_average),
    .out_sum_sq_dev(out_sum_sq_dev)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fold one sample into the running statistics and return the new state
  task automatic fold_sample(input logic [SAMPLE_W-1:0] raw, output stats_t res);
    logic [SAMPLE_W-1:0] x;
    logic [63:0]         xf;
    logic [63:0]         dev_in;
    logic [63:0]         step;
    logic [63:0]         mean_next;
    logic [63:0]         dev_out;
    logic [127:0]        prod;
    logic [64:0]         m2_sum;
    logic                rising;
    x  = raw & SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);
    xf = 64'(x) << FRAC_BITS;
    if (run_count == '0) begin
      // first sample loads everything directly
      run_count = 1;
      run_min   = x;
      run_max   = x;
      run_mean  = xf;
    end else begin
      if (run_count != '1) run_count = run_count + 1'b1;
      if (x < run_min) run_min = x;
      if (x > run_max) run_max = x;
      rising    = (xf >= run_mean);
      dev_in    = rising ? xf - run_mean : run_mean - xf;
      step      = dev_in / 64'(run_count);
      mean_next = rising ? run_mean + step : run_mean - step;
      dev_out   = rising ? xf - mean_next : mean_next - xf;
      // exact product, drop the fraction, saturate the sum
      prod   = (128'(dev_in) * 128'(dev_out)) >> (2 * FRAC_BITS);
      m2_sum = 65'(run_m2) + 65'(prod[63:0]);
      if (prod[127:64] != '0 || m2_sum[64]) run_m2 = '1;
      else run_m2 = m2_sum[63:0];
      run_mean = mean_next;
    end
    res.count      = run_count;
    res.minimum    = run_min;
    res.maximum    = run_max;
    res.average    = run_mean[AVG_W-1:0];
    res.sum_sq_dev = run_m2;
  endtask

  // Offer one sample, wait for its transfer, record the expected statistics
  task automatic offer_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                              input stats_t want);
    stats_t pred;
    while (!(sent_count >= CALM_LO && sent_count < CALM_HI) &&
           $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    fold_sample(s, pred);
    pending_stats.push_back(typed ? want : pred);
    last_sample = s;
    sent_count++;
    @(negedge clk);
  endtask

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    stats_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      seen_count++;
      if (pending_stats.size() == 0) begin
        err_count++;
        $display("%0t ns: unexpected result: expected none, actual count %0h", $time,
                 out_count);
      end else begin
        want = pending_stats.pop_front();
        check_field("count",      64'(want.count),   64'(out_count));
        check_field("minimum",    64'(want.minimum), 64'(out_minimum));
        check_field("maximum",    64'(want.maximum), 64'(out_maximum));
        check_field("average",    64'(want.average), 64'(out_average));
        check_field("sum_sq_dev", want.sum_sq_dev,   out_sum_sq_dev);
      end
    end
  end

  // Stop the run if no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("running_min_max_mean_variance_tb: errors");
      $finish;
    end
  end

  // Result side: random stalls, a calm window and one long hold-off
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!hold_done && seen_count >= HOLD_AT) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (seen_count >= CALM_LO && seen_count < CALM_HI) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    int unsigned         pick;
    int unsigned         width;
    logic [SAMPLE_W-1:0] s;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample    = '0;
    run_count    = '0;
    run_min      = '0;
    run_max      = '0;
    run_mean     = '0;
    run_m2       = '0;
    last_sample  = '0;
    sent_count   = 0;
    seen_count   = 0;
    err_count    = 0;
    quiet_cycles = 0;

    // Opening rows stay small so M2 keeps headroom; closing rows drive it to saturation
    dir_rows = '{
      '{32'd1000, 1'b1, '{32'd1, 32'd1000, 32'd1000, 48'd65536000, 64'd0}},
      '{32'd1000, 1'b1, '{32'd2, 32'd1000, 32'd1000, 48'd65536000, 64'd0}},
      '{32'd0,          1'b0, NO_STATS},
      '{32'd1001,       1'b0, NO_STATS},
      '{32'd999,        1'b0, NO_STATS},
      '{32'd1,          1'b0, NO_STATS},
      '{32'd65535,      1'b0, NO_STATS},
      '{32'd65536,      1'b0, NO_STATS},
      '{32'd2,          1'b0, NO_STATS},
      '{32'd333,        1'b0, NO_STATS},
      '{32'h00AB_CDEF,  1'b0, NO_STATS},
      '{32'd7,          1'b0, NO_STATS},
      '{32'h0000_5555,  1'b0, NO_STATS},
      '{32'h00AA_AAAA,  1'b0, NO_STATS},
      '{32'd500,        1'b0, NO_STATS},
      '{32'hFFFF_FFFF,  1'b0, NO_STATS},
      '{32'd0,          1'b0, NO_STATS},
      '{32'hFFFF_FFFF,  1'b0, NO_STATS},
      '{32'd0,          1'b0, NO_STATS},
      '{32'h8000_0000,  1'b0, NO_STATS},
      '{32'h7FFF_FFFF,  1'b0, NO_STATS},
      '{32'hFFFF_FFFF,  1'b0, NO_STATS},
      '{32'd0,          1'b0, NO_STATS},
      '{32'hFFFF_FFFF,  1'b0, NO_STATS},
      '{32'h5555_5555,  1'b0, NO_STATS}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < OPEN_ROWS; i++)
      offer_sample(dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].want);

    // Random samples: repeats, values near the mean, occasional wide values, mostly narrow values
    for (int i = 0; i < RAND_ITEMS; i++) begin
      pick  = $urandom_range(99);
      width = $urandom_range(24, 1);
      if (pick < 8) begin
        s = last_sample;
      end else if (pick < 20) begin
        s = SAMPLE_W'(run_mean >> FRAC_BITS) + SAMPLE_W'($urandom_range(6)) - 32'd3;
      end else if (pick < 21) begin
        s = $urandom & ((32'd1 << $urandom_range(30, 25)) - 32'd1);
      end else begin
        s = $urandom & ((32'd1 << width) - 32'd1);
      end
      offer_sample(s, 1'b0, NO_STATS);
    end

    for (int i = OPEN_ROWS; i < DIR_ROWS; i++)
      offer_sample(dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].want);

    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_count == 0) begin
      $display("running_min_max_mean_variance_tb: clean");
    end else begin
      $display("running_min_max_mean_variance_tb: errors");
    end
    $finish;
  end

endmodule

[sim.f]
design/rmmv_pkg.sv
design/rmmv_ctrl.sv
design/rmmv_dp.sv
design/running_min_max_mean_variance.sv
tb/running_min_max_mean_variance_tb.sv
